// ===== design/obgr_pkg.sv =====
package obgr_pkg;

  // signed numerator width for the box limit divisions
  localparam int NUM_W   = 22;
  // cell size width
  localparam int CS_W    = 10;
  // sum of squares of the half extents
  localparam int SQN_W   = 27;
  // reach width (ceil root of SQN_W bits)
  localparam int REACH_W = 15;
  // shared multiplier operand and product widths
  localparam int MA_W    = 25;
  localparam int MB_W    = 16;
  localparam int MP_W    = MA_W + MB_W;
  // along / across accumulators
  localparam int ACC_W   = 44;
  localparam int GRID_W  = 12;

  localparam logic [2:0] REG_STAMP_ENABLE = 3'd0;
  localparam logic [2:0] REG_GRID_WIDTH   = 3'd1;
  localparam logic [2:0] REG_GRID_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE    = 3'd3;
  localparam logic [2:0] REG_MARK_VALUE   = 3'd4;

  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

endpackage

// ===== design/obgr_sqrt.sv =====
module obgr_sqrt import obgr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  unit_req_t          req,
  input  logic [SQN_W-1:0]   n,
  output unit_rsp_t          rsp,
  output logic [REACH_W-1:0] root
);

  localparam int XW = SQN_W + 1;
  localparam int ITER = (SQN_W + 1) / 2;
  localparam int CW = $clog2(ITER + 1);

  logic [XW-1:0] x_r, r_r, bit_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [XW-1:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        x_r    <= {1'b0, n};
        r_r    <= '0;
        bit_r  <= XW'(1) << (2 * (ITER - 1));
        cnt_r  <= CW'(ITER);
      end else if (busy_r) begin
        if (x_r >= trial) begin
          x_r <= x_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder left over means the floor root was short
  assign root     = REACH_W'(r_r) + REACH_W'(x_r != '0);
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;

endmodule

// ===== design/obgr_div.sv =====
module obgr_div import obgr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  unit_req_t               req,
  input  logic signed [NUM_W-1:0] num,
  input  logic [CS_W-1:0]         den,
  output unit_rsp_t               rsp,
  output logic signed [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] mag_r;
  logic [CS_W-1:0]  rem_r;
  logic             neg_r, busy_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [CS_W:0]    trial;
  logic             fit;

  assign trial = {rem_r, mag_r[NUM_W-1]};
  assign fit   = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        neg_r  <= num[NUM_W-1];
        mag_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_r  <= '0;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        rem_r <= fit ? CS_W'(trial - {1'b0, den}) : CS_W'(trial);
        mag_r <= {mag_r[NUM_W-2:0], fit};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // floor: a negative quotient with remainder steps one further down
  assign quo = neg_r ? (-$signed(mag_r) - $signed(NUM_W'(rem_r != '0))) : $signed(mag_r);
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;

endmodule

// ===== design/oriented_box_grid_rasterizer_unit.sv =====
// oriented box grid rasterizer
//
// in_*  : one rotated rectangle per transfer (center, cos/sin in Q2.14, half
//         length and half width). in_tready is high only while the sequencer
//         is idle, so one rectangle is worked on at a time.
// out_* : one transfer per grid row of the clipped bounding box, carrying the
//         row, the first column and a column mask; out_tlast marks the final
//         row, out_tuser flags a box that was cut to the mask window. An empty
//         box or stamping disabled gives one zero-mask row with tlast set.
// cfg_* : register writes, always accepted; write only while idle.
//
// work per rectangle: squares of the half extents, root, four serial
// divisions, box and multiplier setup, then per row the multiplier steps,
// a column scan at one mask column per cycle and an emit step.
// the shared multiplier and the one-cell-per-cycle column scan set the pace.
// a stalled receiver holds the pending row in the output register; the
// sequencer waits in its emit step until that row is taken.
// reset returns the registers to 1/256/256/50/100 and idles the sequencer.
module oriented_box_grid_rasterizer_unit import obgr_pkg::*; #(
  parameter int MASK_SPAN = 32,
  parameter int MAX_ROWS  = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x_mm[19:0] center_y_mm[39:20] cos_heading[55:40] sin_heading[71:56]
  // half_length_mm[84:72] half_width_mm[97:85], zero fill above
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index[11:0] col_start[23:12] cover_mask[55:24] cell_value[63:56]
  output logic [63:0]  out_tdata,
  // clipped[0]
  output logic [0:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [12:0]  cfg_data
);

  localparam int SPAN_EFF = (MASK_SPAN < 32) ? MASK_SPAN : 32;
  localparam int ROWS_EFF = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int COL_W    = $clog2(SPAN_EFF);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_HL, S_SQ_HW, S_SQ_SUM, S_SQ_WAIT, S_DIV_GO, S_DIV_WAIT, S_BOX,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_ROW, S_ROW2, S_ROW3, S_CELL,
    S_EMIT, S_EMPTY
  } state_t;

  // configuration
  logic                   stamp_en_r;
  logic [12:0]            grid_w_r, grid_h_r;
  logic [CS_W-1:0]        cs_r;
  logic [7:0]             mark_r;

  state_t                 state_r;

  // latched rectangle
  logic signed [19:0]     cx_r, cy_r;
  logic signed [15:0]     cos_r, sin_r;
  logic [12:0]            hl_r, hw_r;

  logic [SQN_W-1:0]       sqn_r;
  logic [REACH_W-1:0]     reach_r;
  logic [1:0]             dsel_r;
  logic signed [NUM_W-1:0] q_r [4];

  logic [GRID_W-1:0]      c0_r, row_r, r1_r;
  logic [COL_W-1:0]       ncm1_r, col_r;
  logic                   clip_r;

  logic signed [MA_W-1:0] dx_r, dy_r;
  logic signed [ACC_W-1:0] step_c_r, step_s_r, ax_c_r, ax_s_r, along_r, across_r;
  logic [31:0]            mask_r;

  // output register
  logic                   out_valid_r;
  logic [GRID_W-1:0]      o_row_r, o_col_r;
  logic [31:0]            o_mask_r;
  logic [7:0]             o_val_r;
  logic                   o_clip_r, o_last_r;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod_r;

  logic [CS_W-1:0]        cs_eff;
  logic signed [MA_W-1:0] cs2;
  logic [12:0]            gw_eff, gh_eff;

  unit_req_t              sq_req, dv_req;
  unit_rsp_t              sq_rsp, dv_rsp;
  logic [REACH_W-1:0]     sq_root;
  logic signed [NUM_W-1:0] dv_num, dv_quo;

  logic                   accept_in, out_free, emit_now;

  assign cs_eff = (cs_r == '0) ? CS_W'(1) : cs_r;
  assign cs2    = MA_W'({cs_eff, 1'b0});
  assign gw_eff = (grid_w_r > 13'd4096) ? 13'd4096 : grid_w_r;
  assign gh_eff = (grid_h_r > 13'd4096) ? 13'd4096 : grid_h_r;

  assign in_tready = (state_r == S_IDLE);
  assign accept_in = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  // a row or the empty result moves into the output register this cycle
  assign emit_now  = ((state_r == S_EMIT) || (state_r == S_EMPTY)) && out_free;
  assign cfg_ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_en_r <= 1'b1;
      grid_w_r   <= 13'd256;
      grid_h_r   <= 13'd256;
      cs_r       <= CS_W'(50);
      mark_r     <= 8'd100;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_STAMP_ENABLE: stamp_en_r <= cfg_data[0];
        REG_GRID_WIDTH:   grid_w_r   <= cfg_data;
        REG_GRID_HEIGHT:  grid_h_r   <= cfg_data;
        REG_CELL_SIZE:    cs_r       <= cfg_data[CS_W-1:0];
        REG_MARK_VALUE:   mark_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // multiplier operand selection per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ_HL: begin mul_a = MA_W'(hl_r); mul_b = MB_W'(hl_r); end
      S_SQ_HW: begin mul_a = MA_W'(hw_r); mul_b = MB_W'(hw_r); end
      S_M1:    begin mul_a = MA_W'({c0_r, 1'b1});  mul_b = MB_W'(cs_eff); end
      S_M2:    begin mul_a = MA_W'({row_r, 1'b1}); mul_b = MB_W'(cs_eff); end
      S_M3:    begin mul_a = cs2;  mul_b = cos_r; end
      S_M4:    begin mul_a = cs2;  mul_b = sin_r; end
      S_M5:    begin mul_a = dx_r; mul_b = cos_r; end
      S_M6:    begin mul_a = dx_r; mul_b = sin_r; end
      S_ROW:   begin mul_a = dy_r; mul_b = sin_r; end
      S_ROW2:  begin mul_a = dy_r; mul_b = cos_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod_r <= mul_a * mul_b;

  // box limit numerators: x - reach, x + reach, y - reach, y + reach
  always_comb begin
    unique case (dsel_r)
      2'd0:    dv_num = NUM_W'(cx_r) - $signed(NUM_W'(reach_r));
      2'd1:    dv_num = NUM_W'(cx_r) + $signed(NUM_W'(reach_r));
      2'd2:    dv_num = NUM_W'(cy_r) - $signed(NUM_W'(reach_r));
      default: dv_num = NUM_W'(cy_r) + $signed(NUM_W'(reach_r));
    endcase
  end

  assign sq_req.start = (state_r == S_SQ_SUM);
  assign dv_req.start = (state_r == S_DIV_GO);

  obgr_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .n    (sqn_r + SQN_W'(prod_r)),
    .rsp  (sq_rsp),
    .root (sq_root)
  );

  obgr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dv_req),
    .num  (dv_num),
    .den  (cs_eff),
    .rsp  (dv_rsp),
    .quo  (dv_quo)
  );

  // clipping of the divided limits
  logic signed [NUM_W-1:0] bc0, bc1, br0, br1, gw_m1, gh_m1;
  logic                    box_empty, cut_c, cut_r;

  always_comb begin
    gw_m1 = $signed(NUM_W'(gw_eff)) - NUM_W'(1);
    gh_m1 = $signed(NUM_W'(gh_eff)) - NUM_W'(1);
    bc0 = (q_r[0] < 0) ? '0 : q_r[0];
    br0 = (q_r[2] < 0) ? '0 : q_r[2];
    bc1 = (q_r[1] > gw_m1) ? gw_m1 : q_r[1];
    br1 = (q_r[3] > gh_m1) ? gh_m1 : q_r[3];
    box_empty = (bc0 > bc1) || (br0 > br1);
    cut_c = (bc1 - bc0) >= NUM_W'(SPAN_EFF);
    cut_r = (br1 - br0) >= NUM_W'(ROWS_EFF);
  end

  // cell test on the running along / across terms
  logic [ACC_W-1:0] abs_along, abs_across;
  logic             cell_hit;

  assign abs_along  = along_r[ACC_W-1]  ? ACC_W'(-along_r)  : ACC_W'(along_r);
  assign abs_across = across_r[ACC_W-1] ? ACC_W'(-across_r) : ACC_W'(across_r);
  assign cell_hit = (abs_along  <= ACC_W'({hl_r, 15'd0})) &&
                    (abs_across <= ACC_W'({hw_r, 15'd0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dsel_r      <= '0;
    end else begin
      if (emit_now) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept_in) begin
            cx_r  <= in_tdata[19:0];
            cy_r  <= in_tdata[39:20];
            cos_r <= in_tdata[55:40];
            sin_r <= in_tdata[71:56];
            hl_r  <= in_tdata[84:72];
            hw_r  <= in_tdata[97:85];
            state_r <= stamp_en_r ? S_SQ_HL : S_EMPTY;
          end
        end
        S_SQ_HL: state_r <= S_SQ_HW;
        S_SQ_HW: begin
          sqn_r   <= SQN_W'(prod_r);
          state_r <= S_SQ_SUM;
        end
        S_SQ_SUM: state_r <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (sq_rsp.done) begin
            reach_r <= sq_root;
            dsel_r  <= '0;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (dv_rsp.done) begin
            q_r[dsel_r] <= dv_quo;
            dsel_r      <= dsel_r + 2'd1;
            state_r     <= (dsel_r == 2'd3) ? S_BOX : S_DIV_GO;
          end
        end
        S_BOX: begin
          c0_r   <= GRID_W'(bc0);
          row_r  <= GRID_W'(br0);
          ncm1_r <= cut_c ? COL_W'(SPAN_EFF - 1) : COL_W'(bc1 - bc0);
          r1_r   <= cut_r ? GRID_W'(br0 + NUM_W'(ROWS_EFF - 1)) : GRID_W'(br1);
          clip_r <= cut_c || cut_r;
          state_r <= box_empty ? S_EMPTY : S_M1;
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          dx_r    <= MA_W'(prod_r) - (MA_W'(cx_r) <<< 1);
          state_r <= S_M3;
        end
        S_M3: begin
          dy_r    <= MA_W'(prod_r) - (MA_W'(cy_r) <<< 1);
          state_r <= S_M4;
        end
        S_M4: begin
          step_c_r <= ACC_W'(prod_r);
          state_r  <= S_M5;
        end
        S_M5: begin
          step_s_r <= ACC_W'(prod_r);
          state_r  <= S_M6;
        end
        S_M6: begin
          ax_c_r  <= ACC_W'(prod_r);
          state_r <= S_M7;
        end
        S_M7: begin
          ax_s_r  <= ACC_W'(prod_r);
          state_r <= S_ROW;
        end
        S_ROW: state_r <= S_ROW2;
        S_ROW2: begin
          along_r <= ax_c_r + ACC_W'(prod_r);
          state_r <= S_ROW3;
        end
        S_ROW3: begin
          across_r <= ACC_W'(prod_r) - ax_s_r;
          col_r    <= '0;
          mask_r   <= '0;
          state_r  <= S_CELL;
        end
        S_CELL: begin
          mask_r[5'(col_r)] <= cell_hit;
          along_r  <= along_r + step_c_r;
          across_r <= across_r - step_s_r;
          if (col_r == ncm1_r) state_r <= S_EMIT;
          else col_r <= col_r + COL_W'(1);
        end
        S_EMIT: begin
          if (out_free) begin
            o_row_r  <= row_r;
            o_col_r  <= c0_r;
            o_mask_r <= mask_r;
            o_val_r  <= mark_r;
            o_clip_r <= clip_r;
            o_last_r <= (row_r == r1_r);
            if (row_r == r1_r) begin
              state_r <= S_IDLE;
            end else begin
              row_r   <= row_r + GRID_W'(1);
              dy_r    <= dy_r + cs2;
              state_r <= S_ROW;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            o_row_r  <= '0;
            o_col_r  <= '0;
            o_mask_r <= '0;
            o_val_r  <= mark_r;
            o_clip_r <= 1'b0;
            o_last_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_val_r, o_mask_r, o_col_r, o_row_r};
  assign out_tuser  = o_clip_r;
  assign out_tlast  = o_last_r;

  // column scan never runs past the window
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELL) |-> (col_r <= ncm1_r))
    else $error("column counter beyond box width");

  // row walk stays inside the box
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (row_r <= r1_r))
    else $error("row counter beyond last box row");

  // a rectangle is taken only with no unit still running
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in |-> (!sq_rsp.busy && !dv_rsp.busy))
    else $error("rectangle accepted while a shared unit is busy");

  // an empty result is never flagged as cut
  a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMPTY && out_free) |=> (out_tvalid && out_tlast && !out_tuser[0]))
    else $error("empty result malformed");

endmodule

// ===== tb/sv/oriented_box_grid_rasterizer_unit_tb.sv =====
`timescale 1ns / 1ps

module oriented_box_grid_rasterizer_unit_tb;
  import obgr_pkg::*;

  localparam int SPAN = 32;
  localparam int ROWS = 64;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [11:0] row_index;
    logic [11:0] col_start;
    logic [31:0] cover_mask;
    logic [7:0]  cell_value;
    logic        clipped;
    logic        last_row;
  } row_mask_t;

  typedef struct {
    logic signed [19:0] cx;
    logic signed [19:0] cy;
    logic signed [15:0] cos_h;
    logic signed [15:0] sin_h;
    logic [12:0]        hl;
    logic [12:0]        hw;
  } box_t;

  // raster predictor with its own copy of the registers
  class raster_scoreboard;
    row_mask_t pending_rows[$];
    logic        stamp_on;
    logic [12:0] cols_reg;
    logic [12:0] rows_reg;
    logic [9:0]  cell_reg;
    logic [7:0]  mark_reg;
    int          errors;

    function new();
      stamp_on = 1; cols_reg = 256; rows_reg = 256; cell_reg = 50; mark_reg = 100;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] val);
      case (idx)
        REG_STAMP_ENABLE: stamp_on = val[0];
        REG_GRID_WIDTH:   cols_reg = val;
        REG_GRID_HEIGHT:  rows_reg = val[12:0];
        REG_CELL_SIZE:    cell_reg = val[9:0];
        REG_MARK_VALUE:   mark_reg = val[7:0];
        default: ;
      endcase
    endfunction

    function longint fdiv(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q = q - 1;
      return q;
    endfunction

    function longint root_up(longint n);
      longint r;
      r = 0;
      while (r * r < n) r = r + 1;
      return r;
    endfunction

    function void push_empty();
      row_mask_t e;
      e = '0;
      e.cell_value = mark_reg;
      e.last_row = 1;
      pending_rows.insert(pending_rows.size(), e);
    endfunction

    // note an accepted rectangle and queue its rows
    function void note_box(box_t b);
      longint cs, gw, gh, reach, c0, c1, r0, r1, lim_l, lim_w, dx2, dy2, al, ac;
      logic clip;
      row_mask_t e;
      cs = (cell_reg == 0) ? 1 : cell_reg;
      gw = (cols_reg > 4096) ? 4096 : cols_reg;
      gh = (rows_reg > 4096) ? 4096 : rows_reg;
      clip = 0;
      if (!stamp_on) begin
        push_empty();
        return;
      end
      reach = root_up(longint'(b.hl) * b.hl + longint'(b.hw) * b.hw);
      c0 = fdiv(b.cx - reach, cs);
      c1 = fdiv(b.cx + reach, cs);
      r0 = fdiv(b.cy - reach, cs);
      r1 = fdiv(b.cy + reach, cs);
      if (c0 < 0) c0 = 0;
      if (r0 < 0) r0 = 0;
      if (c1 > gw - 1) c1 = gw - 1;
      if (r1 > gh - 1) r1 = gh - 1;
      if (c0 > c1 || r0 > r1) begin
        push_empty();
        return;
      end
      if (c1 - c0 + 1 > SPAN) begin
        c1 = c0 + SPAN - 1; clip = 1;
      end
      if (r1 - r0 + 1 > ROWS) begin
        r1 = r0 + ROWS - 1; clip = 1;
      end
      lim_l = 2 * longint'(b.hl) * 16384;
      lim_w = 2 * longint'(b.hw) * 16384;
      for (longint r = r0; r <= r1; r++) begin
        e = '0;
        dy2 = (2 * r + 1) * cs - 2 * longint'(b.cy);
        for (longint c = c0; c <= c1; c++) begin
          dx2 = (2 * c + 1) * cs - 2 * longint'(b.cx);
          al = dx2 * b.cos_h + dy2 * b.sin_h;
          ac = dy2 * b.cos_h - dx2 * b.sin_h;
          if (al < 0) al = -al;
          if (ac < 0) ac = -ac;
          if (al <= lim_l && ac <= lim_w) e.cover_mask[c - c0] = 1'b1;
        end
        e.row_index = r[11:0];
        e.col_start = c0[11:0];
        e.cell_value = mark_reg;
        e.clipped = clip;
        e.last_row = (r == r1);
        pending_rows.insert(pending_rows.size(), e);
      end
    endfunction

    // compare one accepted row against the oldest expectation
    function void check_row(row_mask_t got);
      row_mask_t w;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row %h", $time, got);
        errors++;
        return;
      end
      w = pending_rows.pop_front();
      if (w.row_index !== got.row_index) begin
        $display("%0t: row_index exp %0d got %0d", $time, w.row_index, got.row_index);
        errors++;
      end
      if (w.col_start !== got.col_start) begin
        $display("%0t: col_start exp %0d got %0d", $time, w.col_start, got.col_start);
        errors++;
      end
      if (w.cover_mask !== got.cover_mask) begin
        $display("%0t: cover_mask exp %h got %h", $time, w.cover_mask, got.cover_mask);
        errors++;
      end
      if (w.cell_value !== got.cell_value) begin
        $display("%0t: cell_value exp %h got %h", $time, w.cell_value, got.cell_value);
        errors++;
      end
      if (w.clipped !== got.clipped) begin
        $display("%0t: clipped exp %b got %b", $time, w.clipped, got.clipped);
        errors++;
      end
      if (w.last_row !== got.last_row) begin
        $display("%0t: last_row exp %b got %b", $time, w.last_row, got.last_row);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // center_x_mm, center_y_mm, cos_heading, sin_heading, half_length_mm, half_width_mm
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // row_index, col_start, cover_mask, cell_value
  logic [63:0]  out_tdata;
  // clipped
  logic [0:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_addr;
  logic [12:0]  cfg_data;

  raster_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  oriented_box_grid_rasterizer_unit #(.MASK_SPAN(SPAN), .MAX_ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver: random backpressure, check each row transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_row({out_tdata[11:0], out_tdata[23:12], out_tdata[55:24],
                      out_tdata[63:56], out_tuser[0], out_tlast});
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_valid <= 1; cfg_addr <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // settle: all expected rows in, then wait out any in-flight work
  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic send_box(box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'd0, b.hw, b.hl, b.sin_h, b.cos_h, b.cy, b.cx};
    do @(posedge clk); while (!in_tready);
    sb.note_box(b);
  endtask

  function automatic box_t make_box(int cs);
    box_t b;
    int k;
    k = $urandom_range(9);
    // mostly boxes landing on the grid, with small extents
    b.cx = $urandom_range(300 * cs) - 20 * cs;
    b.cy = $urandom_range(300 * cs) - 20 * cs;
    b.hl = $urandom_range(6 * cs);
    b.hw = $urandom_range(4 * cs);
    case ($urandom_range(3))
      0: begin b.cos_h = 16384; b.sin_h = 0; end
      1: begin b.cos_h = 11585; b.sin_h = -11585; end
      default: begin
        b.cos_h = $urandom_range(32768) - 16384;
        b.sin_h = $urandom_range(32768) - 16384;
      end
    endcase
    if (k == 0) begin
      b.cx = $urandom; b.cy = $urandom;
      b.cos_h = $urandom; b.sin_h = $urandom;
    end
    if (k == 1) begin
      b.hl = $urandom; b.hw = $urandom;
    end
    return b;
  endfunction

  task automatic directed();
    box_t b;
    b = '{100, 100, 16384, 0, 0, 0};               send_box(b);
    b = '{-524288, -524288, -16384, -16384, 8191, 8191}; send_box(b);
    b = '{524287, 524287, 16384, 16384, 8191, 8191}; send_box(b);
    b = '{6400, 6400, 11585, 11585, 8191, 8191};   send_box(b);  // cut both ways
    b = '{6400, 6400, 16384, 0, 1000, 20};         send_box(b);  // wide only
    b = '{6400, 6400, 0, 16384, 1000, 20};         send_box(b);
    b = '{-50, -50, 16384, 0, 10, 10};             send_box(b);  // off grid
    b = '{25, 25, 16384, 0, 0, 0};                 send_box(b);  // cell center
    b = '{12775, 12775, -16384, 0, 60, 30};        send_box(b);  // grid corner
    b = '{1000, 1000, -32768, 32767, 200, 100};    send_box(b);  // unnormalized
    b = '{1000, 2000, 4096, -15862, 300, 80};      send_box(b);
  endtask

  task automatic random_phase(int n, int cs);
    for (int i = 0; i < n; i++) send_box(make_box(cs));
  endtask

  initial begin
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    cfg_valid = 0; cfg_addr = REG_STAMP_ENABLE; cfg_data = '0;
    send_idle_pct = 21; recv_idle_pct = 80;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // defaults after reset
    directed();
    random_phase(60, 50);
    drain();

    // stamping off, mark value with only the top bit set
    write_reg(REG_STAMP_ENABLE, 0);
    write_reg(REG_MARK_VALUE, 13'h080);
    random_phase(15, 50);
    drain();

    // tiny cells, tiny grid, then other idle mix
    send_idle_pct = 80; recv_idle_pct = 21;
    write_reg(REG_STAMP_ENABLE, 1);
    write_reg(REG_CELL_SIZE, 1);
    write_reg(REG_GRID_WIDTH, 1);
    write_reg(REG_GRID_HEIGHT, 1);
    write_reg(REG_MARK_VALUE, 13'h07f);
    directed();
    random_phase(40, 1);
    drain();

    // max grid, large cell size, zero-sized grid, saturation, zero cell
    write_reg(REG_GRID_WIDTH, 4096);
    write_reg(REG_GRID_HEIGHT, 13'h1fff);
    write_reg(REG_CELL_SIZE, 1000);
    random_phase(60, 1000);
    drain();
    write_reg(REG_MARK_VALUE, 13'h1fff);
    write_reg(REG_GRID_WIDTH, 0);
    random_phase(10, 50);
    drain();
    write_reg(REG_GRID_WIDTH, 13'h1fff);
    write_reg(REG_GRID_HEIGHT, 100);
    write_reg(REG_CELL_SIZE, 0);
    random_phase(20, 1);
    drain();

    // no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_CELL_SIZE, 13'h3ff);
    write_reg(REG_GRID_WIDTH, 300);
    write_reg(REG_MARK_VALUE, 13'h055);
    random_phase(100, 1023);
    drain();
    write_reg(REG_CELL_SIZE, 37);
    random_phase(100, 37);
    drain();

    if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
